// ===== src/sbdp_pkg.sv =====
// shared constants, types and hash functions of the skewed branch predictor
package sbdp_pkg;

    localparam int INDEX_BITS   = 12;
    localparam int HISTORY_BITS = 16;
    localparam int COUNTER_BITS = 2;

    localparam int BANK_DEPTH = 1 << INDEX_BITS;
    localparam logic [COUNTER_BITS-1:0] CTR_MAX    = {COUNTER_BITS{1'b1}};
    localparam logic [COUNTER_BITS-1:0] CTR_THRESH = COUNTER_BITS'(1 << (COUNTER_BITS - 1));
    localparam logic [COUNTER_BITS-1:0] CTR_INIT   = CTR_THRESH - COUNTER_BITS'(1);
    localparam logic [63:0] TOP_MASK = 64'h8000000000000000;
    localparam logic [63:0] LOW_MASK = 64'h7FFFFFFFFFFFFFFF;

    typedef enum logic [1:0] {
        OP_PREDICT = 2'd0,
        OP_TRAIN   = 2'd1,
        OP_RESTORE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC
    } back_state_t;

    typedef logic [INDEX_BITS-1:0]   index_t;
    typedef logic [HISTORY_BITS-1:0] hist_t;
    typedef logic [COUNTER_BITS-1:0] ctr_t;

    // input beat
    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] branch_address;
        logic        outcome_taken;
        logic [15:0] history_value;
    } item_t;

    // result beat
    typedef struct packed {
        logic        predicted_taken;
        logic [15:0] history_now;
    } result_t;

    // classified command from front to back
    typedef struct packed {
        op_t    op;
        index_t idx0;
        index_t idx1;
        index_t idx2;
        logic   taken;
        hist_t  hist;
    } cmd_t;

    // status from back to front
    typedef struct packed {
        logic  ready;
        logic  take;
        logic  done;
        hist_t history;
    } back_status_t;

    // one-bit right shift dropping bit63, new top bit is bit0 ^ bit63
    function automatic logic [63:0] skew_h(input logic [63:0] v);
        logic [63:0] top;
        top = (v ^ (v << 63)) & TOP_MASK;
        return top | ((v & LOW_MASK) >> 1);
    endfunction

    // inverse for inputs with bit63 clear: left shift, new bit0 is bit63 ^ bit62
    function automatic logic [63:0] skew_hinv(input logic [63:0] v);
        logic [63:0] bottom;
        bottom = ((v >> 63) ^ (v >> 62)) & 64'd1;
        return (v << 1) | bottom;
    endfunction

    // saturating counter step
    function automatic ctr_t ctr_train(input ctr_t c, input logic taken);
        ctr_t r;
        if (taken)
            r = (c < CTR_MAX) ? c + ctr_t'(1) : CTR_MAX;
        else
            r = (c > ctr_t'(0)) ? c - ctr_t'(1) : ctr_t'(0);
        return r;
    endfunction

endpackage

// ===== src/skewed_branch_direction_predictor_core.sv =====
// top level of the three-bank skewed branch direction predictor
//
// input channel: an item beat is taken at a clock edge with push high and
// full low; it carries an operation (predict, train, restore history),
// the branch address, the training outcome and a history value.
// result channel: while empty is low the oldest result is on result;
// it is taken at an edge with pop high. every item gives one result.
// one item is worked on at a time: a predict or train item goes through the
// command register, the registered bank read and the exec state before its
// result is queued, while restore and unused codes skip the exec state; the
// next item is taken only once the last is done, a pace set by the registered
// read of the counter banks and the history that the next prediction needs
// from this one's vote. after reset a clearing pass sets all 4096 counters of
// each bank to weakly not taken, one entry per cycle; full stays high until
// the pass is done. a stalled receiver fills a two-entry result queue; once
// it is full the block still accepts one more item, which waits in the
// command register, then holds full high until the receiver pops.
module skewed_branch_direction_predictor_core
    import sbdp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    back_status_t status;
    logic         cmd_valid;
    cmd_t         cmd;

    // classification and hashing
    sbdp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .status    (status),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // banks, history and results
    sbdp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .status    (status),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== src/sbdp_front.sv =====
// front end: accepts input beats, classifies them and computes bank indexes
module sbdp_front
    import sbdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  item_t        item,
    input  back_status_t status,
    output logic         cmd_valid,
    output cmd_t         cmd
);

    logic  in_flight_reg, in_flight_next;
    logic  cmd_valid_reg, cmd_valid_next;
    cmd_t  cmd_reg, cmd_next;
    logic  accept;
    op_t   op;
    hist_t hist_sel;
    logic [63:0] a, h, ha, hia, hh, hih;

    assign full   = in_flight_reg | ~status.ready;
    assign accept = push & ~full;
    assign op     = op_t'(item.operation);

    // history under which the banks are indexed
    always_comb
    begin
        if (op == OP_PREDICT)
            hist_sel = status.history;
        else
            hist_sel = hist_t'(64'(item.history_value));
    end

    // skewing hashes
    always_comb
    begin
        a   = item.branch_address >> 4;
        h   = 64'(hist_sel);
        ha  = skew_h(a);
        hia = skew_hinv(a);
        hh  = skew_h(h);
        hih = skew_hinv(h);
    end

    // command register and occupancy
    always_comb
    begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        in_flight_next = in_flight_reg;
        if (status.take)
            cmd_valid_next = 1'b0;
        if (status.done)
            in_flight_next = 1'b0;
        if (accept)
        begin
            cmd_next.op    = op;
            cmd_next.idx0  = index_t'(ha ^ hih ^ h);
            cmd_next.idx1  = index_t'(ha ^ hih ^ a);
            cmd_next.idx2  = index_t'(hia ^ hh ^ h);
            cmd_next.taken = item.outcome_taken;
            cmd_next.hist  = hist_t'(64'(item.history_value));
            cmd_valid_next = 1'b1;
            in_flight_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            in_flight_reg <= in_flight_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== src/sbdp_back.sv =====
// back end: counter banks, vote, training, history and result queue
module sbdp_back
    import sbdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    input  cmd_t         cmd,
    output back_status_t status,
    output logic         empty,
    input  logic         pop,
    output result_t      result
);

    back_state_t state_reg, state_next;
    index_t  clear_addr_reg, clear_addr_next;
    hist_t   hist_reg, hist_next;
    cmd_t    work_reg;
    ctr_t    bank0 [BANK_DEPTH];
    ctr_t    bank1 [BANK_DEPTH];
    ctr_t    bank2 [BANK_DEPTH];
    ctr_t    rd0_reg, rd1_reg, rd2_reg;
    logic    take, done, mem_we, res_push, vote;
    index_t  wa0, wa1, wa2;
    ctr_t    wd0, wd1, wd2;
    result_t res_in;

    result_t     oq_reg [2];
    logic        oq_wr_reg, oq_rd_reg;
    logic [1:0]  oq_count_reg, oq_count_next;
    logic        oq_pop, oq_space;

    assign oq_space = (oq_count_reg != 2'd2);
    assign oq_pop   = pop & (oq_count_reg != 2'd0);

    assign vote = (rd0_reg[COUNTER_BITS-1] & rd1_reg[COUNTER_BITS-1])
                | (rd0_reg[COUNTER_BITS-1] & rd2_reg[COUNTER_BITS-1])
                | (rd1_reg[COUNTER_BITS-1] & rd2_reg[COUNTER_BITS-1]);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        hist_next       = hist_reg;
        take            = 1'b0;
        done            = 1'b0;
        mem_we          = 1'b0;
        res_push        = 1'b0;
        res_in          = '0;
        wa0 = work_reg.idx0;
        wa1 = work_reg.idx1;
        wa2 = work_reg.idx2;
        wd0 = ctr_train(rd0_reg, work_reg.taken);
        wd1 = ctr_train(rd1_reg, work_reg.taken);
        wd2 = ctr_train(rd2_reg, work_reg.taken);
        unique case (state_reg)
            BS_CLEAR:
            begin
                mem_we = 1'b1;
                wa0 = clear_addr_reg;
                wa1 = clear_addr_reg;
                wa2 = clear_addr_reg;
                wd0 = CTR_INIT;
                wd1 = CTR_INIT;
                wd2 = CTR_INIT;
                clear_addr_next = clear_addr_reg + index_t'(1);
                if (clear_addr_reg == {INDEX_BITS{1'b1}})
                    state_next = BS_IDLE;
            end
            BS_IDLE:
            begin
                if (cmd_valid && oq_space)
                begin
                    take = 1'b1;
                    unique case (cmd.op)
                        OP_PREDICT, OP_TRAIN:
                            state_next = BS_EXEC;
                        OP_RESTORE:
                        begin
                            hist_next = cmd.hist;
                            res_push  = 1'b1;
                            res_in.history_now = 16'(64'(cmd.hist));
                            done      = 1'b1;
                        end
                        OP_NONE:
                        begin
                            res_push  = 1'b1;
                            res_in.history_now = 16'(64'(hist_reg));
                            done      = 1'b1;
                        end
                    endcase
                end
            end
            BS_EXEC:
            begin
                res_push   = 1'b1;
                done       = 1'b1;
                state_next = BS_IDLE;
                if (work_reg.op == OP_PREDICT)
                begin
                    hist_next = (hist_reg << 1) | hist_t'(vote);
                    res_in.predicted_taken = vote;
                    res_in.history_now = 16'(64'(hist_next));
                end
                else
                begin
                    mem_we = 1'b1;
                    res_in.history_now = 16'(64'(hist_reg));
                end
            end
            default:
                state_next = BS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BS_CLEAR;
            clear_addr_reg <= '0;
            hist_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            hist_reg       <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            work_reg <= cmd;
    end

    // counter banks
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bank0[wa0] <= wd0;
            bank1[wa1] <= wd1;
            bank2[wa2] <= wd2;
        end
        rd0_reg <= bank0[cmd.idx0];
        rd1_reg <= bank1[cmd.idx1];
        rd2_reg <= bank2[cmd.idx2];
    end

    // result queue
    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (res_push && !oq_pop)
            oq_count_next = oq_count_reg + 2'd1;
        else if (!res_push && oq_pop)
            oq_count_next = oq_count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= 2'd0;
        end
        else
        begin
            oq_count_reg <= oq_count_next;
            if (res_push)
                oq_wr_reg <= ~oq_wr_reg;
            if (oq_pop)
                oq_rd_reg <= ~oq_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            oq_reg[oq_wr_reg] <= res_in;
    end

    assign empty  = (oq_count_reg == 2'd0);
    assign result = oq_reg[oq_rd_reg];

    assign status.ready   = (state_reg != BS_CLEAR);
    assign status.take    = take;
    assign status.done    = done;
    assign status.history = hist_reg;

endmodule
